// ----- src/rvcie_pkg.sv -----
`default_nettype none

package rvcie_pkg;

    // RV32I major opcodes
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // Fixed register numbers
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

    // Quadrant codes in the low two bits
    localparam logic [1:0] QUAD_0 = 2'b00;
    localparam logic [1:0] QUAD_1 = 2'b01;
    localparam logic [1:0] QUAD_2 = 2'b10;

    // Compressed instruction classes after the first decode
    typedef enum logic [4:0] {
        CLS_ILLEGAL,
        CLS_NOP,
        CLS_EBREAK,
        CLS_ADDI4SPN,
        CLS_LW,
        CLS_SW,
        CLS_ADDI,
        CLS_JAL,
        CLS_LI,
        CLS_ADDI16SP,
        CLS_LUI,
        CLS_SRLI,
        CLS_SRAI,
        CLS_ANDI,
        CLS_SUB,
        CLS_XOR,
        CLS_OR,
        CLS_AND,
        CLS_J,
        CLS_BEQZ,
        CLS_BNEZ,
        CLS_SLLI,
        CLS_LWSP,
        CLS_JR,
        CLS_MV,
        CLS_JALR,
        CLS_ADD,
        CLS_SWSP
    } cls_t;

    // 32-bit encoding formats
    typedef enum logic [2:0] {
        FMT_ZERO,
        FMT_I,
        FMT_S,
        FMT_B,
        FMT_J,
        FMT_R,
        FMT_U
    } fmt_t;

    // Fields of the expanded instruction before assembly
    typedef struct packed {
        fmt_t        fmt;
        logic [6:0]  op;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [20:0] imm;
    } fields_t;

endpackage

`default_nettype wire

// ----- src/rvc_instruction_expander.sv -----
`default_nettype none

// Channel  | Dir | Payload                                   | Handshake
// s_*      | in  | tdata[15:0] half_instruction              | s_tvalid / s_tready
// m_*      | out | tdata[31:0] expanded_instruction, tuser   | m_tvalid / m_tready
//          |     | [0] is_illegal                            |
//
// One request accepted per cycle unless the output stalls; its result is registered in
// each stage. Stage 1 classifies the compressed word, stage 2 forms the
// 32-bit fields and immediates, stage 3 assembles the word into the output register.
// rst_n clears all stage valid bits; payload registers are not reset.
// A stall holds each stage only while it is full and the next one is blocked,
// so bubbles collapse and no request is lost or repeated.
module rvc_instruction_expander
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] half_instruction
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] expanded_instruction
    output logic             m_tuser    // [0] is_illegal
);
    import rvcie_pkg::*;

    logic        v1_reg, v1_next;
    logic [15:0] instr1_reg;
    cls_t        cls1_reg;
    logic        v2_reg, v2_next;
    fields_t     fld2_reg;
    logic        v3_reg, v3_next;
    logic [31:0] word3_reg;
    logic        ill3_reg;

    logic        ready1, ready2, ready3;
    cls_t        cls_d;
    fields_t     fld_d;
    logic [31:0] word_d;

    // Stage ready chain: a stage takes new data when empty or draining
    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;

    // Classify the compressed word
    always_comb
    begin
        logic [1:0] q;
        logic [2:0] f3;
        logic [4:0] rd;
        logic [4:0] rs2;
        logic       imm6_zero;
        q         = s_tdata[1:0];
        f3        = s_tdata[15:13];
        rd        = s_tdata[11:7];
        rs2       = s_tdata[6:2];
        imm6_zero = (s_tdata[12] == 1'b0) && (rs2 == 5'd0);
        cls_d     = CLS_ILLEGAL;
        if (s_tdata != 16'd0)
        begin
            case (q)
                QUAD_0:
                begin
                    case (f3)
                        3'd0:    cls_d = (s_tdata[12:5] == 8'd0) ? CLS_ILLEGAL : CLS_ADDI4SPN;
                        3'd2:    cls_d = CLS_LW;
                        3'd6:    cls_d = CLS_SW;
                        default: cls_d = CLS_ILLEGAL;
                    endcase
                end
                QUAD_1:
                begin
                    case (f3)
                        3'd0: cls_d = (rd == REG_ZERO || imm6_zero) ? CLS_NOP : CLS_ADDI;
                        3'd1: cls_d = CLS_JAL;
                        3'd2: cls_d = (rd == REG_ZERO) ? CLS_NOP : CLS_LI;
                        3'd3:
                        begin
                            if (imm6_zero)
                                cls_d = CLS_ILLEGAL;
                            else if (rd == REG_SP)
                                cls_d = CLS_ADDI16SP;
                            else if (rd == REG_ZERO)
                                cls_d = CLS_NOP;
                            else
                                cls_d = CLS_LUI;
                        end
                        3'd4:
                        begin
                            case (s_tdata[11:10])
                                2'd0: cls_d = s_tdata[12] ? CLS_ILLEGAL : CLS_SRLI;
                                2'd1: cls_d = s_tdata[12] ? CLS_ILLEGAL : CLS_SRAI;
                                2'd2: cls_d = CLS_ANDI;
                                default:
                                begin
                                    if (s_tdata[12])
                                        cls_d = CLS_ILLEGAL;
                                    else
                                    begin
                                        case (s_tdata[6:5])
                                            2'd0:    cls_d = CLS_SUB;
                                            2'd1:    cls_d = CLS_XOR;
                                            2'd2:    cls_d = CLS_OR;
                                            default: cls_d = CLS_AND;
                                        endcase
                                    end
                                end
                            endcase
                        end
                        3'd5:    cls_d = CLS_J;
                        3'd6:    cls_d = CLS_BEQZ;
                        default: cls_d = CLS_BNEZ;
                    endcase
                end
                QUAD_2:
                begin
                    case (f3)
                        3'd0:
                        begin
                            if (s_tdata[12])
                                cls_d = CLS_ILLEGAL;
                            else
                                cls_d = (rd == REG_ZERO) ? CLS_NOP : CLS_SLLI;
                        end
                        3'd2: cls_d = (rd == REG_ZERO) ? CLS_ILLEGAL : CLS_LWSP;
                        3'd4:
                        begin
                            if (!s_tdata[12])
                            begin
                                if (rs2 == REG_ZERO)
                                    cls_d = (rd == REG_ZERO) ? CLS_ILLEGAL : CLS_JR;
                                else
                                    cls_d = (rd == REG_ZERO) ? CLS_NOP : CLS_MV;
                            end
                            else
                            begin
                                if (rs2 == REG_ZERO)
                                    cls_d = (rd == REG_ZERO) ? CLS_EBREAK : CLS_JALR;
                                else
                                    cls_d = (rd == REG_ZERO) ? CLS_NOP : CLS_ADD;
                            end
                        end
                        3'd6:    cls_d = CLS_SWSP;
                        default: cls_d = CLS_ILLEGAL;
                    endcase
                end
                default: cls_d = CLS_ILLEGAL;
            endcase
        end
    end

    // Form the 32-bit fields and immediates from the class
    always_comb
    begin
        logic [15:0] c;
        logic [4:0]  rdp;
        logic [4:0]  rsp;
        logic [20:0] imm6_sx;
        logic [20:0] jimm_sx;
        logic [20:0] bimm_sx;
        logic [20:0] sp16_sx;
        c       = instr1_reg;
        rdp     = {2'b01, c[4:2]};
        rsp     = {2'b01, c[9:7]};
        imm6_sx = {{15{c[12]}}, c[12], c[6:2]};
        jimm_sx = {{9{c[12]}}, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
        bimm_sx = {{12{c[12]}}, c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
        sp16_sx = {{11{c[12]}}, c[12], c[4:3], c[5], c[2], c[6], 4'b0000};

        fld_d     = '0;
        fld_d.fmt = FMT_I;
        fld_d.op  = OP_IMM;
        fld_d.f7  = F7_BASE;
        case (cls1_reg)
            CLS_NOP: ;
            CLS_EBREAK:
            begin
                fld_d.op  = OP_SYSTEM;
                fld_d.imm = 21'd1;
            end
            CLS_ADDI4SPN:
            begin
                fld_d.rs1 = REG_SP;
                fld_d.rd  = rdp;
                fld_d.imm = {11'd0, c[10:7], c[12:11], c[5], c[6], 2'b00};
            end
            CLS_LW:
            begin
                fld_d.op  = OP_LOAD;
                fld_d.f3  = 3'd2;
                fld_d.rs1 = rsp;
                fld_d.rd  = rdp;
                fld_d.imm = {14'd0, c[5], c[12:10], c[6], 2'b00};
            end
            CLS_SW:
            begin
                fld_d.fmt = FMT_S;
                fld_d.op  = OP_STORE;
                fld_d.f3  = 3'd2;
                fld_d.rs1 = rsp;
                fld_d.rs2 = rdp;
                fld_d.imm = {14'd0, c[5], c[12:10], c[6], 2'b00};
            end
            CLS_ADDI:
            begin
                fld_d.rs1 = c[11:7];
                fld_d.rd  = c[11:7];
                fld_d.imm = imm6_sx;
            end
            CLS_JAL, CLS_J:
            begin
                fld_d.fmt = FMT_J;
                fld_d.op  = OP_JAL;
                fld_d.rd  = (cls1_reg == CLS_JAL) ? REG_RA : REG_ZERO;
                fld_d.imm = jimm_sx;
            end
            CLS_LI:
            begin
                fld_d.rd  = c[11:7];
                fld_d.imm = imm6_sx;
            end
            CLS_ADDI16SP:
            begin
                fld_d.rs1 = REG_SP;
                fld_d.rd  = REG_SP;
                fld_d.imm = sp16_sx;
            end
            CLS_LUI:
            begin
                fld_d.fmt = FMT_U;
                fld_d.op  = OP_LUI;
                fld_d.rd  = c[11:7];
                fld_d.imm = imm6_sx;
            end
            CLS_SRLI, CLS_SRAI:
            begin
                fld_d.fmt = FMT_R;
                fld_d.f7  = (cls1_reg == CLS_SRAI) ? F7_ALT : F7_BASE;
                fld_d.f3  = 3'd5;
                fld_d.rs2 = c[6:2];
                fld_d.rs1 = rsp;
                fld_d.rd  = rsp;
            end
            CLS_ANDI:
            begin
                fld_d.f3  = 3'd7;
                fld_d.rs1 = rsp;
                fld_d.rd  = rsp;
                fld_d.imm = imm6_sx;
            end
            CLS_SUB, CLS_XOR, CLS_OR, CLS_AND:
            begin
                fld_d.fmt = FMT_R;
                fld_d.op  = OP_REG;
                fld_d.rs2 = rdp;
                fld_d.rs1 = rsp;
                fld_d.rd  = rsp;
                case (cls1_reg)
                    CLS_SUB:
                    begin
                        fld_d.f7 = F7_ALT;
                        fld_d.f3 = 3'd0;
                    end
                    CLS_XOR: fld_d.f3 = 3'd4;
                    CLS_OR:  fld_d.f3 = 3'd6;
                    default: fld_d.f3 = 3'd7;
                endcase
            end
            CLS_BEQZ, CLS_BNEZ:
            begin
                fld_d.fmt = FMT_B;
                fld_d.op  = OP_BRANCH;
                fld_d.f3  = (cls1_reg == CLS_BNEZ) ? 3'd1 : 3'd0;
                fld_d.rs1 = rsp;
                fld_d.rs2 = REG_ZERO;
                fld_d.imm = bimm_sx;
            end
            CLS_SLLI:
            begin
                fld_d.f3  = 3'd1;
                fld_d.rs1 = c[11:7];
                fld_d.rd  = c[11:7];
                fld_d.imm = {16'd0, c[6:2]};
            end
            CLS_LWSP:
            begin
                fld_d.op  = OP_LOAD;
                fld_d.f3  = 3'd2;
                fld_d.rs1 = REG_SP;
                fld_d.rd  = c[11:7];
                fld_d.imm = {13'd0, c[3:2], c[12], c[6:4], 2'b00};
            end
            CLS_JR, CLS_JALR:
            begin
                fld_d.op  = OP_JALR;
                fld_d.rs1 = c[11:7];
                fld_d.rd  = (cls1_reg == CLS_JALR) ? REG_RA : REG_ZERO;
            end
            CLS_MV, CLS_ADD:
            begin
                fld_d.fmt = FMT_R;
                fld_d.op  = OP_REG;
                fld_d.rs2 = c[6:2];
                fld_d.rs1 = (cls1_reg == CLS_ADD) ? c[11:7] : REG_ZERO;
                fld_d.rd  = c[11:7];
            end
            CLS_SWSP:
            begin
                fld_d.fmt = FMT_S;
                fld_d.op  = OP_STORE;
                fld_d.f3  = 3'd2;
                fld_d.rs1 = REG_SP;
                fld_d.rs2 = c[6:2];
                fld_d.imm = {13'd0, c[8:7], c[12:9], 2'b00};
            end
            default: fld_d.fmt = FMT_ZERO;
        endcase
    end

    // Assemble the 32-bit word by format
    always_comb
    begin
        fields_t f;
        f = fld2_reg;
        case (f.fmt)
            FMT_I:   word_d = {f.imm[11:0], f.rs1, f.f3, f.rd, f.op};
            FMT_S:   word_d = {f.imm[11:5], f.rs2, f.rs1, f.f3, f.imm[4:0], f.op};
            FMT_B:   word_d = {f.imm[12], f.imm[10:5], f.rs2, f.rs1, f.f3,
                               f.imm[4:1], f.imm[11], f.op};
            FMT_J:   word_d = {f.imm[20], f.imm[10:1], f.imm[11], f.imm[19:12],
                               f.rd, f.op};
            FMT_R:   word_d = {f.f7, f.rs2, f.rs1, f.f3, f.rd, f.op};
            FMT_U:   word_d = {f.imm[19:0], f.rd, f.op};
            default: word_d = 32'd0;
        endcase
    end

    // Advance valid bits
    always_comb
    begin
        v1_next = ready1 ? s_tvalid : v1_reg;
        v2_next = ready2 ? v1_reg   : v2_reg;
        v3_next = ready3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Load stage payloads only when a stage takes a request
    always_ff @(posedge clk)
    begin
        if (ready1 && s_tvalid)
        begin
            instr1_reg <= s_tdata;
            cls1_reg   <= cls_d;
        end
        if (ready2 && v1_reg)
            fld2_reg <= fld_d;
        if (ready3 && v2_reg)
        begin
            word3_reg <= word_d;
            ill3_reg  <= (fld2_reg.fmt == FMT_ZERO);
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = word3_reg;
    assign m_tuser  = ill3_reg;

    // An illegal result carries an all-zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
        else $error("illegal result with nonzero word");

    // A legal result is always a 32-bit encoding
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[1:0] == 2'b11))
        else $error("legal result without 32-bit opcode");

    // An empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output stage");

    // An accepted request occupies stage one on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted request lost in stage one");

endmodule

`default_nettype wire

// ----- test/rvc_instruction_expander_test.sv -----
`default_nettype none

module rvc_instruction_expander_test;

    import rvcie_pkg::*;

    // Compressed funct3 selectors, per quadrant
    localparam logic [2:0] Q0_ADDI4SPN = 3'd0;
    localparam logic [2:0] Q0_LW       = 3'd2;
    localparam logic [2:0] Q0_SW       = 3'd6;
    localparam logic [2:0] Q1_ADDI     = 3'd0;
    localparam logic [2:0] Q1_JAL      = 3'd1;
    localparam logic [2:0] Q1_LI       = 3'd2;
    localparam logic [2:0] Q1_LUI      = 3'd3;
    localparam logic [2:0] Q1_ARITH    = 3'd4;
    localparam logic [2:0] Q1_J        = 3'd5;
    localparam logic [2:0] Q1_BEQZ     = 3'd6;
    localparam logic [2:0] Q1_BNEZ     = 3'd7;
    localparam logic [2:0] Q2_SLLI     = 3'd0;
    localparam logic [2:0] Q2_LWSP     = 3'd2;
    localparam logic [2:0] Q2_JR_ADD   = 3'd4;
    localparam logic [2:0] Q2_SWSP     = 3'd6;

    // Sub-selectors of the quadrant 1 arithmetic group
    localparam logic [1:0] ARITH_SRLI = 2'd0;
    localparam logic [1:0] ARITH_SRAI = 2'd1;
    localparam logic [1:0] ARITH_ANDI = 2'd2;
    localparam logic [1:0] REG_SUB    = 2'd0;
    localparam logic [1:0] REG_XOR    = 2'd1;
    localparam logic [1:0] REG_OR     = 2'd2;

    // RV32I funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [31:0] CANON_NOP  = 32'h0000_0013;
    localparam logic [11:0] EBREAK_IMM = 12'd1;

    localparam int N_RANDOM     = 1000;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_AT      = 300;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int DRAIN_LIMIT  = 10000;

    typedef struct {
        logic [31:0] word;
        logic        illegal;
    } expansion_t;

    // Predict each accepted word and match it against the output stream
    class expansion_checker;
        expansion_t pending_words[$];
        int         n_checked;
        int         n_illegal;
        int         n_errors;

        function logic [31:0] pack_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                     logic [4:0] rd, logic [6:0] op);
            return {imm, rs1, f3, rd, op};
        endfunction

        function logic [31:0] pack_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                     logic [2:0] f3, logic [6:0] op);
            return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
        endfunction

        function logic [31:0] pack_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                     logic [2:0] f3, logic [6:0] op);
            return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], op};
        endfunction

        function logic [31:0] pack_j(logic [20:0] imm, logic [4:0] rd, logic [6:0] op);
            return {imm[20], imm[10:1], imm[11], imm[19:12], rd, op};
        endfunction

        function logic [31:0] pack_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                     logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
            return {f7, rs2, rs1, f3, rd, op};
        endfunction

        function logic [31:0] expand_rvc(logic [15:0] c);
            logic [2:0]  f3;
            logic [4:0]  rd;
            logic [4:0]  rs2;
            logic [4:0]  rp;
            logic [4:0]  r2p;
            logic [6:0]  mem_off;
            logic [9:0]  spn_imm;
            logic [11:0] imm6;
            logic [11:0] sp16_imm;
            logic [20:0] jimm;
            logic [12:0] bimm;
            logic [7:0]  lwsp_off;
            logic [7:0]  swsp_off;
            f3       = c[15:13];
            rd       = c[11:7];
            rs2      = c[6:2];
            rp       = {2'b01, c[9:7]};
            r2p      = {2'b01, c[4:2]};
            mem_off  = {c[5], c[12:10], c[6], 2'b00};
            spn_imm  = {c[10:7], c[12:11], c[5], c[6], 2'b00};
            imm6     = {{7{c[12]}}, c[6:2]};
            sp16_imm = {{3{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0000};
            jimm     = {{10{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
            bimm     = {{5{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
            lwsp_off = {c[3:2], c[12], c[6:4], 2'b00};
            swsp_off = {c[8:7], c[12:9], 2'b00};

            if (c == 16'h0000)
                return 32'd0;
            case (c[1:0])
                QUAD_0:
                begin
                    case (f3)
                        Q0_ADDI4SPN:
                            return (spn_imm == 10'd0) ? 32'd0 :
                                pack_i({2'b00, spn_imm}, REG_SP, F3_ADD, r2p, OP_IMM);
                        Q0_LW: return pack_i({5'd0, mem_off}, rp, F3_WORD, r2p, OP_LOAD);
                        Q0_SW: return pack_s({5'd0, mem_off}, r2p, rp, F3_WORD, OP_STORE);
                        default: return 32'd0;
                    endcase
                end
                QUAD_1:
                begin
                    case (f3)
                        Q1_ADDI:
                            return (rd == REG_ZERO || imm6 == 12'd0) ? CANON_NOP :
                                pack_i(imm6, rd, F3_ADD, rd, OP_IMM);
                        Q1_JAL: return pack_j(jimm, REG_RA, OP_JAL);
                        Q1_LI:
                            return (rd == REG_ZERO) ? CANON_NOP :
                                pack_i(imm6, REG_ZERO, F3_ADD, rd, OP_IMM);
                        Q1_LUI:
                        begin
                            if (rd == REG_SP)
                                return (sp16_imm == 12'd0) ? 32'd0 :
                                    pack_i(sp16_imm, REG_SP, F3_ADD, REG_SP, OP_IMM);
                            if (imm6 == 12'd0)
                                return 32'd0;
                            return (rd == REG_ZERO) ? CANON_NOP :
                                {{15{c[12]}}, c[6:2], rd, OP_LUI};
                        end
                        Q1_ARITH:
                        begin
                            case (c[11:10])
                                ARITH_SRLI:
                                    return c[12] ? 32'd0 :
                                        pack_r(F7_BASE, rs2, rp, F3_SR, rp, OP_IMM);
                                ARITH_SRAI:
                                    return c[12] ? 32'd0 :
                                        pack_r(F7_ALT, rs2, rp, F3_SR, rp, OP_IMM);
                                ARITH_ANDI: return pack_i(imm6, rp, F3_AND, rp, OP_IMM);
                                default:
                                begin
                                    // word forms and the reserved group are not RV32
                                    if (c[12])
                                        return 32'd0;
                                    case (c[6:5])
                                        REG_SUB:
                                            return pack_r(F7_ALT, r2p, rp, F3_ADD, rp, OP_REG);
                                        REG_XOR:
                                            return pack_r(F7_BASE, r2p, rp, F3_XOR, rp, OP_REG);
                                        REG_OR:
                                            return pack_r(F7_BASE, r2p, rp, F3_OR, rp, OP_REG);
                                        default:
                                            return pack_r(F7_BASE, r2p, rp, F3_AND, rp, OP_REG);
                                    endcase
                                end
                            endcase
                        end
                        Q1_J: return pack_j(jimm, REG_ZERO, OP_JAL);
                        Q1_BEQZ: return pack_b(bimm, REG_ZERO, rp, F3_BEQ, OP_BRANCH);
                        Q1_BNEZ: return pack_b(bimm, REG_ZERO, rp, F3_BNE, OP_BRANCH);
                        default: return 32'd0;
                    endcase
                end
                QUAD_2:
                begin
                    case (f3)
                        Q2_SLLI:
                        begin
                            if (c[12])
                                return 32'd0;
                            return (rd == REG_ZERO) ? CANON_NOP :
                                pack_i({7'd0, rs2}, rd, F3_SLL, rd, OP_IMM);
                        end
                        Q2_LWSP:
                            return (rd == REG_ZERO) ? 32'd0 :
                                pack_i({4'd0, lwsp_off}, REG_SP, F3_WORD, rd, OP_LOAD);
                        Q2_JR_ADD:
                        begin
                            if (!c[12])
                            begin
                                if (rs2 == REG_ZERO)
                                    return (rd == REG_ZERO) ? 32'd0 :
                                        pack_i(12'd0, rd, F3_ADD, REG_ZERO, OP_JALR);
                                return (rd == REG_ZERO) ? CANON_NOP :
                                    pack_r(F7_BASE, rs2, REG_ZERO, F3_ADD, rd, OP_REG);
                            end
                            if (rs2 == REG_ZERO)
                                return (rd == REG_ZERO) ?
                                    pack_i(EBREAK_IMM, REG_ZERO, F3_ADD, REG_ZERO, OP_SYSTEM) :
                                    pack_i(12'd0, rd, F3_ADD, REG_RA, OP_JALR);
                            return (rd == REG_ZERO) ? CANON_NOP :
                                pack_r(F7_BASE, rs2, rd, F3_ADD, rd, OP_REG);
                        end
                        Q2_SWSP: return pack_s({4'd0, swsp_off}, rs2, REG_SP, F3_WORD, OP_STORE);
                        default: return 32'd0;
                    endcase
                end
                default: return 32'd0;
            endcase
        endfunction

        function void note_request(logic [15:0] half);
            expansion_t e;
            e.word    = expand_rvc(half);
            e.illegal = (e.word == 32'd0);
            pending_words.push_back(e);
        endfunction

        function void check_result(logic [31:0] word, logic illegal);
            expansion_t e;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected result word %h illegal %b", $time, word, illegal);
                n_errors++;
                return;
            end
            e = pending_words.pop_front();
            n_checked++;
            if (illegal)
                n_illegal++;
            if (word !== e.word)
            begin
                $display("%0t: expanded_instruction expected %h actual %h",
                         $time, e.word, word);
                n_errors++;
            end
            if (illegal !== e.illegal)
            begin
                $display("%0t: is_illegal expected %b actual %b", $time, e.illegal, illegal);
                n_errors++;
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    bit tail_phase   = 1'b0;
    bit hold_request = 1'b0;
    int n_directed   = 0;
    int n_random     = 0;

    expansion_checker board = new();

    rvc_instruction_expander u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Offer one request, with an occasional gap before it, and hold until accepted
    task automatic offer_request(input logic [15:0] half);
        if (!tail_phase && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= half;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(half);
    endtask

    // Draw a word, mostly from the three compressed quadrants
    function automatic logic [15:0] random_half();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(0, 9) != 0)
            w[1:0] = 2'($urandom_range(0, 2));
        return w;
    endfunction

    // Sink results, with short random stalls and one long hold-off
    initial
    begin
        int   stall_left;
        logic ready_next;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            ready_next = 1'b1;
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            else if (stall_left == 0 && !tail_phase && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0)
            begin
                ready_next = 1'b0;
                stall_left--;
            end
            m_tready <= ready_next;
        end
    end

    initial
    begin
        logic [15:0] directed_words[$];
        int          guard;
        directed_words = '{
            16'h0000, 16'hFFFF, 16'h0004, 16'h1FFC, 16'hDFFC, 16'h8000, 16'hE000,
            16'hE002, 16'hA002, 16'h0001, 16'h1FFD, 16'h4001, 16'h6101, 16'h717D,
            16'h6081, 16'h9001, 16'h8001, 16'h8C61, 16'h9C01, 16'hBFFD, 16'hC001,
            16'hFFFD, 16'h0002, 16'h1082, 16'h4002, 16'h8002, 16'h9002, 16'h9FFE,
            16'h80FA, 16'h5FFE
        };
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 16'd0;
        m_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: field extremes, reserved codes, hints, ebreak
        foreach (directed_words[i])
        begin
            offer_request(directed_words[i]);
            n_directed++;
        end

        // Random words; stall the sink for a long stretch partway through
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == HOLD_AT)
                hold_request = 1'b1;
            if (i == N_RANDOM - TAIL_ITEMS)
                tail_phase = 1'b1;
            offer_request(random_half());
            n_random++;
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline
        guard = 0;
        while (board.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (board.pending() != 0)
        begin
            $display("rvc_instruction_expander verification failed");
            $finish;
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            $display("Sent %0d directed and %0d random compressed words under random stalls.",
                     n_directed, n_random);
            $display("Compared %0d expansions, %0d of them illegal; %0d mismatches.",
                     board.n_checked, board.n_illegal, board.n_errors);
            if (board.n_errors == 0)
                $display("rvc_instruction_expander verification clean");
            else
                $display("rvc_instruction_expander verification failed");
            $finish;
        end
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("rvc_instruction_expander verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- rvc_instruction_expander.f -----
src/rvcie_pkg.sv
src/rvc_instruction_expander.sv
test/rvc_instruction_expander_test.sv
